// File: rtl/pol_pkg.sv
// Shared types and codes for the positional ordered list.
package pol_pkg;

   // Operation codes carried in the mode field
   localparam logic [2:0] MODE_INS_FRONT = 3'd0;
   localparam logic [2:0] MODE_INS_BACK  = 3'd1;
   localparam logic [2:0] MODE_INS_POS   = 3'd2;
   localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
   localparam logic [2:0] MODE_DEL_POS   = 3'd5;
   localparam logic [2:0] MODE_DUMP      = 3'd6;

   // Result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_BEYOND = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;

   // What every cell of the chain does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

// File: rtl/pol_cell.sv
// One storage cell of the list chain; takes the new value, a neighbor's value or the head's value, or holds.
module pol_cell
   import pol_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int IDX        = 0,
   localparam int IW        = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  cell_op_type                  op,
   input  logic [IW-1:0]                sel_idx,
   input  logic [IW-1:0]                last_idx,
   input  logic signed [DATA_WIDTH-1:0] new_value,
   input  logic signed [DATA_WIDTH-1:0] head_value,
   input  logic signed [DATA_WIDTH-1:0] prev_value,
   input  logic signed [DATA_WIDTH-1:0] next_value,
   output logic signed [DATA_WIDTH-1:0] value_out
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (op)
         CELL_INSERT: begin
            if (MY_IDX > sel_idx) begin
               value_in = prev_value;
            end else if (MY_IDX == sel_idx) begin
               value_in = new_value;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= sel_idx) begin
               value_in = next_value;
            end
         end
         CELL_ROTATE: begin
            // rotate only the occupied part; tail wraps to the old head
            if (MY_IDX == last_idx) begin
               value_in = head_value;
            end else if (MY_IDX < last_idx) begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// File: rtl/positional_ordered_list.sv
// Top level of the positional ordered list: control, fill count and cell chain.
//
// Ordered list of up to CAPACITY signed values, held in a chain of cells with
// a fill count. Each request beat is one operation: insert front, insert back,
// insert at a one-based position, delete front, delete back, delete at a
// position, or dump (positions 0 and 1 mean the front). An edit moves every
// cell at once and is done in the cycle it is accepted; its single response
// beat is presented the next cycle, and a new request can be taken every
// cycle as long as responses drain. A dump of n values (n > 0) rotates the
// occupied cells once per response beat, one beat per cycle while rsp_stall
// lets them drain, and it holds req_stall until the last beat is registered;
// the chain is back in order when the last beat (last = 1) goes out.
// A dump of an empty list answers one beat with status empty. Refused
// operations (full, empty, position beyond the list) leave the list as is.
// Cells need no reset; only occupied cells are ever read.
module positional_ordered_list
   import pol_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IW = $clog2(CAPACITY);      // cell index width
   localparam int FW = $clog2(CAPACITY + 1);  // fill count width
   localparam int CW = ((FW > 8) ? FW : 8) + 1; // width for position compares

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] cnt_ff, cnt_in;      // dump beat counter
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic accept;
   logic out_free;   // response register can take a beat this cycle

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Decode of the request against the current fill
   // ---------------------------------------------------------------------
   logic [1:0]                   dec_status;
   cell_op_type                  dec_op;
   logic [IW-1:0]                dec_idx;
   logic [FW-1:0]                dec_fill;
   logic                         dec_dump;
   logic [CW-1:0]                pos_c, fill_c;
   logic                         is_full, is_empty;
   logic [IW-1:0]                pos_idx;   // position - 1, or front for 0 and 1
   logic signed [DATA_WIDTH-1:0] new_value;

   assign pos_c     = CW'(req_payload.position);
   assign fill_c    = CW'(fill_ff);
   assign is_full   = (fill_ff == FW'(CAPACITY));
   assign is_empty  = (fill_ff == '0);
   assign pos_idx   = (req_payload.position <= 8'd1) ? '0
                                                      : IW'(req_payload.position - 8'd1);
   assign new_value = DATA_WIDTH'(req_payload.value);

   always_comb begin
      dec_status = STAT_OK;
      dec_op     = CELL_HOLD;
      dec_idx    = '0;
      dec_fill   = fill_ff;
      dec_dump   = 1'b0;
      unique case (req_payload.mode)
         MODE_INS_FRONT: begin
            if (is_full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_op   = CELL_INSERT;
               dec_fill = fill_ff + FW'(1);
            end
         end
         MODE_INS_BACK: begin
            if (is_full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_op   = CELL_INSERT;
               dec_idx  = IW'(fill_ff);
               dec_fill = fill_ff + FW'(1);
            end
         end
         MODE_INS_POS: begin
            // beyond check ranks above the full check
            if (pos_c >= fill_c + CW'(2)) begin
               dec_status = STAT_BEYOND;
            end else if (is_full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_op   = CELL_INSERT;
               dec_idx  = pos_idx;
               dec_fill = fill_ff + FW'(1);
            end
         end
         MODE_DEL_FRONT: begin
            if (is_empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_op   = CELL_DELETE;
               dec_fill = fill_ff - FW'(1);
            end
         end
         MODE_DEL_BACK: begin
            if (is_empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_op   = CELL_DELETE;
               dec_idx  = IW'(fill_ff - FW'(1));
               dec_fill = fill_ff - FW'(1);
            end
         end
         MODE_DEL_POS: begin
            if (is_empty) begin
               dec_status = STAT_EMPTY;
            end else if (req_payload.position > 8'd1 && pos_c > fill_c) begin
               dec_status = STAT_BEYOND;
            end else begin
               dec_op   = CELL_DELETE;
               dec_idx  = pos_idx;
               dec_fill = fill_ff - FW'(1);
            end
         end
         MODE_DUMP: begin
            if (is_empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_dump = 1'b1;
            end
         end
         default: begin
            // unused code: no change, answers ok
            dec_status = STAT_OK;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   cell_op_type                  chain_op;
   logic [IW-1:0]                chain_idx;
   logic [IW-1:0]                last_idx;
   logic signed [DATA_WIDTH-1:0] cell_q [CAPACITY];
   logic                         dump_last;

   assign last_idx  = IW'(fill_ff - FW'(1));
   assign dump_last = (cnt_ff == fill_ff - FW'(1));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] prev_v, next_v;

      if (i == 0) begin : g_first
         assign prev_v = new_value;       // never selected at the front
      end else begin : g_mid
         assign prev_v = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_v = cell_q[i];
      end else begin : g_body
         assign next_v = cell_q[i+1];
      end

      pol_cell #(
         .CAPACITY  (CAPACITY),
         .DATA_WIDTH(DATA_WIDTH),
         .IDX       (i)
      ) u_cell (
         .clock     (clock),
         .op        (chain_op),
         .sel_idx   (chain_idx),
         .last_idx  (last_idx),
         .new_value (new_value),
         .head_value(cell_q[0]),
         .prev_value(prev_v),
         .next_value(next_v),
         .value_out (cell_q[i])
      );
   end

   // ---------------------------------------------------------------------
   // Control FSM: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && dec_dump) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control FSM: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      chain_op     = CELL_HOLD;
      chain_idx    = dec_idx;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               chain_op = dec_op;
               fill_in  = dec_fill;
               if (!dec_dump) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = dec_status;
                  rsp_in.data_out    = '0;
                  rsp_in.entry_count = 5'(dec_fill);
                  rsp_in.last        = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               // stream the head, then rotate the occupied cells by one
               chain_op           = CELL_ROTATE;
               cnt_in             = cnt_ff + FW'(1);
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STAT_OK;
               rsp_in.data_out    = 32'(cell_q[0]);
               rsp_in.entry_count = 5'(fill_ff);
               rsp_in.last        = dump_last;
            end
         end
         default: begin
            chain_op = CELL_HOLD;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAPACITY))
      else $error("fill count above capacity");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (cnt_ff < fill_ff))
      else $error("dump counter past fill");

   a_fill_stable_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |=> $stable(fill_ff))
      else $error("fill changed during dump");

   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && out_free && dump_last) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.last))
      else $error("dump did not end on its last beat");
`endif

endmodule

// File: tb/tb_positional_ordered_list.sv
// Self-checking testbench for the positional ordered list: directed table, then random ops.
module tb_positional_ordered_list
   import pol_pkg::*;
();

   localparam int          CAPACITY    = 16;
   localparam int          DATA_WIDTH  = 32;
   localparam int          RANDOM_OPS  = 340;
   localparam int          CALM_OPS    = 50;     // tail of the run with no idling at all
   localparam int          PAUSE_AT    = 170;    // random op before which the sender drains
   localparam int          DRAIN_WAIT  = 20;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam logic [2:0]  MODE_NONE   = 3'd7;   // unused code, answers ok and does nothing

   // One row of the directed table. When fixed is set the expected beat is typed
   // in; otherwise the list predictor supplies it.
   typedef struct {
      req_type     beat;
      int unsigned repeats;
      bit          fixed;
      rsp_type     want;
   } script_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Predictor state: list contents front to back, and beats owed by the block
   logic signed [31:0] list_model[$];
   rsp_type            owed_beats[$];

   int unsigned     mismatches  = 0;
   int unsigned     cycle_count = 0;
   bit              calm        = 1'b0;  // set for the final stretch: no idling either side
   bit              growing     = 1'b1;  // random walk direction of the fill level
   script_row_type  script[$];

   positional_ordered_list #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // List predictor: applies one op to list_model and queues the beats the
   // block owes for it. Every op gives one beat with last set, except a dump
   // of a non-empty list, which streams each value front to back.
   // ---------------------------------------------------------------------
   function automatic void apply_list_op(input req_type op);
      int unsigned fill;
      rsp_type     beat;
      fill = list_model.size();
      beat = '{status: STAT_OK, data_out: '0, entry_count: '0, last: 1'b1};
      case (op.mode)
         MODE_INS_FRONT: begin
            if (fill >= CAPACITY) beat.status = STAT_FULL;
            else list_model.push_front(op.value);
         end
         MODE_INS_BACK: begin
            if (fill >= CAPACITY) beat.status = STAT_FULL;
            else list_model.push_back(op.value);
         end
         MODE_INS_POS: begin
            // beyond-list check wins over the full check
            if (op.position >= fill + 2) beat.status = STAT_BEYOND;
            else if (fill >= CAPACITY) beat.status = STAT_FULL;
            else if (op.position <= 1) list_model.push_front(op.value);
            else list_model.insert(op.position - 1, op.value);
         end
         MODE_DEL_FRONT: begin
            if (fill == 0) beat.status = STAT_EMPTY;
            else void'(list_model.pop_front());
         end
         MODE_DEL_BACK: begin
            if (fill == 0) beat.status = STAT_EMPTY;
            else void'(list_model.pop_back());
         end
         MODE_DEL_POS: begin
            if (fill == 0) beat.status = STAT_EMPTY;
            else if (op.position <= 1) void'(list_model.pop_front());
            else if (op.position > fill) beat.status = STAT_BEYOND;
            else list_model.delete(op.position - 1);
         end
         MODE_DUMP: begin
            if (fill == 0) beat.status = STAT_EMPTY;
            else begin
               // all but the final value go out with last low
               for (int i = 0; i + 1 < fill; i++) begin
                  owed_beats.push_back('{status: STAT_OK, data_out: list_model[i],
                                         entry_count: fill[4:0], last: 1'b0});
               end
               beat.data_out = list_model[fill - 1];
            end
         end
         default: ;  // unused code: no change, status ok
      endcase
      beat.entry_count = 5'(list_model.size());
      owed_beats.push_back(beat);
   endfunction

   // Random op shaped by the fill level: the walk climbs to full, lingers a
   // little so full refusals show up, then drains to empty and lingers there.
   function automatic req_type next_list_op();
      req_type     op;
      int unsigned fill;
      int unsigned roll;
      fill = list_model.size();
      if (fill >= CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (fill == 0 && $urandom_range(0, 1) == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;

      roll = $urandom_range(0, 99);
      if (growing) begin
         if (roll < 20)      op.mode = MODE_INS_FRONT;
         else if (roll < 40) op.mode = MODE_INS_BACK;
         else if (roll < 65) op.mode = MODE_INS_POS;
         else if (roll < 72) op.mode = MODE_DEL_FRONT;
         else if (roll < 79) op.mode = MODE_DEL_BACK;
         else if (roll < 90) op.mode = MODE_DEL_POS;
         else if (roll < 98) op.mode = MODE_DUMP;
         else                op.mode = MODE_NONE;
      end else begin
         if (roll < 7)       op.mode = MODE_INS_FRONT;
         else if (roll < 14) op.mode = MODE_INS_BACK;
         else if (roll < 24) op.mode = MODE_INS_POS;
         else if (roll < 44) op.mode = MODE_DEL_FRONT;
         else if (roll < 64) op.mode = MODE_DEL_BACK;
         else if (roll < 88) op.mode = MODE_DEL_POS;
         else if (roll < 97) op.mode = MODE_DUMP;
         else                op.mode = MODE_NONE;
      end

      // positions mostly land inside the list, often right on its edges
      roll = $urandom_range(0, 9);
      if (roll == 0)      op.position = 8'($urandom_range(0, 255));
      else if (roll == 1) op.position = 8'(fill + $urandom_range(1, 2));
      else                op.position = 8'($urandom_range(0, fill + 1));

      roll = $urandom_range(0, 7);
      case (roll)
         0:       op.value = 32'sh8000_0000;
         1:       op.value = 32'sh7fff_ffff;
         2:       op.value = -32'sd1;
         3:       op.value = '0;
         default: op.value = $urandom;
      endcase
      return op;
   endfunction

   function automatic script_row_type script_row(input logic [2:0] mode,
                                                 input logic [31:0] value,
                                                 input logic [7:0] position,
                                                 input int unsigned repeats,
                                                 input bit fixed,
                                                 input logic [1:0] status,
                                                 input logic [4:0] count);
      script_row_type row;
      row.beat    = '{mode: mode, value: value, position: position};
      row.repeats = repeats;
      row.fixed   = fixed;
      row.want    = '{status: status, data_out: '0, entry_count: count, last: 1'b1};
      return row;
   endfunction

   // Present one request beat and hold it until the block takes it.
   task automatic push_beat(input req_type op);
      req_payload <= op;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender idling: random bursts of random length with valid low.
   task automatic maybe_idle(input bit allow);
      if (allow && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed table. Rows whose outcome is obvious (empty list, refusals,
   // first inserts) carry typed-in beats; all other rows, such as shifts, dumps
   // and mid-list edits, go through the predictor.
   // ---------------------------------------------------------------------
   initial begin : build_script
      // empty list: every delete flavor, dump, and a positional insert past the end
      script.push_back(script_row(MODE_DUMP,      32'h0,         8'd0,   1, 1, STAT_EMPTY,  5'd0));
      script.push_back(script_row(MODE_DEL_FRONT, 32'h0,         8'd0,   1, 1, STAT_EMPTY,  5'd0));
      script.push_back(script_row(MODE_DEL_BACK,  32'hffff_ffff, 8'd255, 1, 1, STAT_EMPTY,  5'd0));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd3,   1, 1, STAT_EMPTY,  5'd0));
      script.push_back(script_row(MODE_INS_POS,   32'h1234_5678, 8'd2,   1, 1, STAT_BEYOND, 5'd0));
      // first values, extremes of the data field
      script.push_back(script_row(MODE_INS_POS,   32'h7fff_ffff, 8'd0,   1, 1, STAT_OK,     5'd1));
      script.push_back(script_row(MODE_INS_FRONT, 32'h8000_0000, 8'd0,   1, 1, STAT_OK,     5'd2));
      script.push_back(script_row(MODE_INS_BACK,  32'hffff_ffff, 8'd0,   1, 1, STAT_OK,     5'd3));
      script.push_back(script_row(MODE_INS_POS,   32'h0,         8'd255, 1, 1, STAT_BEYOND, 5'd3));
      // position count+1 appends; mid-list inserts
      script.push_back(script_row(MODE_INS_POS,   32'h0,         8'd4,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_INS_POS,   32'h5,         8'd1,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_INS_POS,   32'h5555_5555, 8'd3,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd7,   1, 1, STAT_BEYOND, 5'd6));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd0,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd3,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_NONE,      32'haaaa_aaaa, 8'haa,  1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DUMP,      32'h0,         8'd0,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DEL_BACK,  32'h0,         8'd0,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd255, 1, 1, STAT_BEYOND, 5'd3));
      // fill to capacity, then every insert flavor is refused
      script.push_back(script_row(MODE_INS_BACK,  32'h100,       8'd0,  13, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_INS_FRONT, 32'h1,         8'd0,   1, 1, STAT_FULL,   5'd16));
      script.push_back(script_row(MODE_INS_POS,   32'h2,         8'd1,   1, 1, STAT_FULL,   5'd16));
      script.push_back(script_row(MODE_INS_POS,   32'h3,         8'd17,  1, 1, STAT_FULL,   5'd16));
      script.push_back(script_row(MODE_INS_POS,   32'h4,         8'd18,  1, 1, STAT_BEYOND, 5'd16));
      script.push_back(script_row(MODE_INS_BACK,  32'h5,         8'd0,   1, 1, STAT_FULL,   5'd16));
      // longest dump, then drop the last position
      script.push_back(script_row(MODE_DUMP,      32'h0,         8'd0,   1, 0, STAT_OK,     5'd0));
      script.push_back(script_row(MODE_DEL_POS,   32'h0,         8'd16,  1, 0, STAT_OK,     5'd0));
   end

   // ---------------------------------------------------------------------
   // Stimulus: reset, directed table, random walk with one full drain in
   // the middle, calm tail, then wait for the block to pay all beats.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_type op;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (int k = 0; k < script[i].repeats; k++) begin
            op       = script[i].beat;
            op.value = op.value + k;   // repeated rows store distinct values
            push_beat(op);
            apply_list_op(op);
            if (script[i].fixed) begin
               // typed rows are single-beat ops: swap the predicted beat for the typed one
               void'(owed_beats.pop_back());
               owed_beats.push_back(script[i].want);
            end
            maybe_idle(1'b1);
         end
      end

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == PAUSE_AT) begin
            // sender holds off until every owed beat has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (owed_beats.size() != 0) @(posedge clock);
         end
         if (n == RANDOM_OPS - CALM_OPS) calm = 1'b1;
         op = next_list_op();
         push_beat(op);
         apply_list_op(op);
         // every third window of 40 ops runs with no sender gaps
         maybe_idle(!calm && ((n / 40) % 3 != 2));
      end
      req_valid <= 1'b0;

      while (owed_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver idling: stall bursts of random length, with quiet stretches between.
   initial begin : rsp_idler
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 63) == 0) begin
            repeat ($urandom_range(30, 90)) @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Every accepted response beat is matched against the oldest owed beat.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_beats.size() == 0) begin
            $display("%0t: unexpected beat expected none got %p", $time, rsp_payload);
            mismatches++;
         end else begin
            want = owed_beats.pop_front();
            check_field("status",      32'(want.status),      32'(rsp_payload.status));
            check_field("data_out",    32'(want.data_out),    32'(rsp_payload.data_out));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_payload.entry_count));
            check_field("last",        32'(want.last),        32'(rsp_payload.last));
         end
      end
   end

   // Cycle limit: far above the slowest legal run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
tb/tb_positional_ordered_list.sv
